// ===== src/plid_pkg.sv =====
package plid_pkg;

    // Field widths fixed by the stream format
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 7;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 2;
    localparam int ECOUNT_W  = 7;
    localparam int S_TDATA_W = 72;   // position + payload, padded to bytes
    localparam int M_TDATA_W = 72;   // read_data + entry_count, padded to bytes

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF  = 64;
    localparam int DATA_W_DEF = 64;

    // Fan-in of one node of the read-back tree
    localparam int FANIN = 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_READ      = 3'd2;
    localparam logic [FUNC_W-1:0] FN_OVERWRITE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOPOS = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_BUSY,
        SQ_PARK
    } seq_state_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic             go;    // a transaction is accepted this cycle
        logic             ins;   // insert, checked ok
        logic             del;   // delete, checked ok
        logic             wr;    // overwrite, checked ok
        logic             rd;    // read, checked ok
        logic [POS_W-1:0] pos;
    } plid_cmd_t;

    // Number of nodes on tree level lvl for n leaves
    function automatic int tree_nodes(input int n, input int lvl);
        int k;
        int i;
        k = n;
        for (i = 0; i < lvl; i++) begin
            k = (k + FANIN - 1) / FANIN;
        end
        return k;
    endfunction

    // Number of registered tree levels down to one node
    function automatic int tree_levels(input int n);
        int k;
        int l;
        k = n;
        l = 0;
        while (k > 1) begin
            k = (k + FANIN - 1) / FANIN;
            l++;
        end
        return l;
    endfunction

endpackage

// ===== src/positional_insert_delete_list.sv =====
// Channel  Dir  tdata (low bit up)                      tuser
// s_*      in   position[6:0], payload[70:7], pad       func[2:0]
// m_*      out  read_data[63:0], entry_count[70:64], pad status[1:0]
//
// One transaction runs from accept through the busy state, while the read data
// climbs the L levels of the fan-in-8 read-back tree (ceil(log8(DEPTH)), 2 for
// DEPTH = 64), to the park state, before the next accept. Cells shift in the
// accept cycle; the read data then climbs the registered OR tree.
// Reset empties the list at once; entries are left as they are.
// A result parks while m_tready is low; no new item is taken until it moves out.
module positional_insert_delete_list #(
    parameter int DEPTH  = plid_pkg::DEPTH_DEF,
    parameter int DATA_W = plid_pkg::DATA_W_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [plid_pkg::S_TDATA_W-1:0]   s_tdata,   // position, payload
    input  logic [plid_pkg::FUNC_W-1:0]      s_tuser,   // func
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [plid_pkg::M_TDATA_W-1:0]   m_tdata,   // read_data, entry_count
    output logic [plid_pkg::STATUS_W-1:0]    m_tuser    // status
);
    import plid_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CW     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LVLS   = tree_levels(DEPTH);
    localparam int WAIT_W = (LVLS > 1) ? $clog2(LVLS) : 1;

    // Input fields
    logic [FUNC_W-1:0]    func;
    logic [POS_W-1:0]     position;
    logic [PAYLOAD_W-1:0] payload;
    logic [DATA_W-1:0]    wdata;

    assign func     = s_tuser;
    assign position = s_tdata[POS_W-1:0];
    assign payload  = s_tdata[POS_W+PAYLOAD_W-1:POS_W];
    assign wdata    = payload[DATA_W-1:0];

    // Control state
    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic [WAIT_W-1:0]   wait_reg;
    logic [WAIT_W-1:0]   wait_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] status_now;

    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic       accept;
    logic       load_out;
    logic       full;
    logic       pos_gt;
    logic       pos_ge;
    plid_cmd_t  cmd;

    logic [DATA_W-1:0] ent   [DEPTH];
    logic [DATA_W-1:0] rdp   [DEPTH];
    logic [DATA_W-1:0] rd_top;

    assign accept = s_tvalid && s_tready;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign pos_gt = (CW'(position) > CW'(count_reg));
    assign pos_ge = (CW'(position) >= CW'(count_reg));

    // Check the operation against the list and build the cell command
    always_comb
    begin
        status_now = ST_OK;
        count_next = count_reg;
        cmd        = '0;
        cmd.go     = accept;
        cmd.pos    = position;
        unique case (func)
            FN_INSERT:
            begin
                priority if (full)
                begin
                    status_now = ST_FULL;
                end
                else if (pos_gt)
                begin
                    status_now = ST_NOPOS;
                end
                else
                begin
                    cmd.ins    = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            FN_DELETE:
            begin
                if (pos_ge)
                begin
                    status_now = ST_NOPOS;
                end
                else
                begin
                    cmd.del    = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            FN_READ:
            begin
                if (pos_ge)
                begin
                    status_now = ST_NOPOS;
                end
                else
                begin
                    cmd.rd = accept;
                end
            end
            FN_OVERWRITE:
            begin
                if (pos_ge)
                begin
                    status_now = ST_NOPOS;
                end
                else
                begin
                    cmd.wr = accept;
                end
            end
            FN_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = SQ_BUSY;
                    wait_next  = WAIT_W'(LVLS - 1);
                end
            end
            SQ_BUSY:
            begin
                if (wait_reg == '0)
                begin
                    state_next = SQ_PARK;
                end
                else
                begin
                    wait_next = wait_reg - 1'b1;
                end
            end
            SQ_PARK:
            begin
                if (load_out)
                begin
                    state_next = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            SQ_IDLE:
            begin
                s_tready = 1'b1;
            end
            SQ_BUSY:
            begin
                s_tready = 1'b0;
            end
            SQ_PARK:
            begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SQ_IDLE;
            wait_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Hold the status and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_status_reg <= status_now;
        end
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= rd_top;
            out_count_reg  <= count_reg;
        end
    end

    // Row of cells, one list entry each
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] lft;
        logic [DATA_W-1:0] rgt;
        if (i == 0)
        begin : g_first
            assign lft = '0;
        end
        else
        begin : g_mid_l
            assign lft = ent[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign rgt = ent[i];
        end
        else
        begin : g_mid_r
            assign rgt = ent[i+1];
        end
        plid_cell #(
            .DEPTH  (DEPTH),
            .DATA_W (DATA_W),
            .IDX    (i)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .wdata   (wdata),
            .left    (lft),
            .right   (rgt),
            .entry   (ent[i]),
            .rd_part (rdp[i])
        );
    end

    // Collect the selected entry
    plid_or_tree #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_tree (
        .clk    (clk),
        .leaves (rdp),
        .top    (rd_top)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_TDATA_W'({ECOUNT_W'(out_count_reg), PAYLOAD_W'(out_data_reg)});

endmodule

// ===== src/plid_cell.sv =====
module plid_cell #(
    parameter int DEPTH  = plid_pkg::DEPTH_DEF,
    parameter int DATA_W = plid_pkg::DATA_W_DEF,
    parameter int IDX    = 0
) (
    input  logic                clk,
    input  plid_pkg::plid_cmd_t cmd,
    input  logic [DATA_W-1:0]   wdata,
    input  logic [DATA_W-1:0]   left,     // entry of the cell one position lower
    input  logic [DATA_W-1:0]   right,    // entry of the cell one position higher
    output logic [DATA_W-1:0]   entry,
    output logic [DATA_W-1:0]   rd_part   // own entry when selected for read, else zero
);
    import plid_pkg::*;

    localparam int IW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = (IW > POS_W) ? IW : POS_W;

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic [DATA_W-1:0] rdp_reg;
    logic [DATA_W-1:0] rdp_next;
    logic              hit;
    logic              above;

    assign hit   = (CW'(cmd.pos) == CW'(IDX));
    assign above = (CW'(IDX) > CW'(cmd.pos));

    // Pick the new entry: shift up, shift down, take new data or hold
    always_comb
    begin
        priority if (cmd.ins && above)
        begin
            entry_next = left;
        end
        else if ((cmd.ins || cmd.wr) && hit)
        begin
            entry_next = wdata;
        end
        else if (cmd.del && (above || hit))
        begin
            entry_next = right;
        end
        else
        begin
            entry_next = entry_reg;
        end
        rdp_next = (cmd.rd && hit) ? entry_reg : '0;
    end

    // Update only on an accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            entry_reg <= entry_next;
            rdp_reg   <= rdp_next;
        end
    end

    assign entry   = entry_reg;
    assign rd_part = rdp_reg;

endmodule

// ===== src/plid_or_tree.sv =====
module plid_or_tree #(
    parameter int DEPTH  = plid_pkg::DEPTH_DEF,
    parameter int DATA_W = plid_pkg::DATA_W_DEF
) (
    input  logic              clk,
    input  logic [DATA_W-1:0] leaves [DEPTH],
    output logic [DATA_W-1:0] top
);
    import plid_pkg::*;

    localparam int LVLS = tree_levels(DEPTH);

    logic [DATA_W-1:0] node [LVLS+1][DEPTH];

    // Level zero is the row of cell read outputs
    for (genvar n = 0; n < DEPTH; n++)
    begin : g_leaf
        assign node[0][n] = leaves[n];
    end

    // Each level ORs groups of FANIN nodes of the level below into a register
    for (genvar l = 1; l <= LVLS; l++)
    begin : g_lvl
        localparam int NPREV = tree_nodes(DEPTH, l - 1);
        localparam int NCUR  = tree_nodes(DEPTH, l);
        for (genvar n = 0; n < DEPTH; n++)
        begin : g_node
            if (n < NCUR)
            begin : g_used
                logic [DATA_W-1:0] kids [FANIN];
                logic [DATA_W-1:0] acc;
                for (genvar j = 0; j < FANIN; j++)
                begin : g_kid
                    if (n * FANIN + j < NPREV)
                    begin : g_real
                        assign kids[j] = node[l-1][n * FANIN + j];
                    end
                    else
                    begin : g_pad
                        assign kids[j] = '0;
                    end
                end
                always_comb
                begin
                    acc = '0;
                    for (int j = 0; j < FANIN; j++)
                    begin
                        acc = acc | kids[j];
                    end
                end
                always_ff @(posedge clk)
                begin
                    node[l][n] <= acc;
                end
            end
            else
            begin : g_unused
                assign node[l][n] = '0;
            end
        end
    end

    assign top = node[LVLS][0];

endmodule

// ===== src/plid_checker.sv =====
module plid_checker #(
    parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [plid_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [plid_pkg::STATUS_W-1:0]    m_tuser
);
    import plid_pkg::*;

    // One transaction at a time: an accept closes the input for the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // Status is one of the three defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == ST_OK) || (m_tuser == ST_FULL) || (m_tuser == ST_NOPOS)))
        else $error("undefined status code");

    // A refused operation returns no data
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[PAYLOAD_W-1:0] == '0))
        else $error("refused operation returned data");

    // Entry count never exceeds the list depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((DEPTH > 127) || (m_tdata[PAYLOAD_W +: ECOUNT_W] <= ECOUNT_W'(DEPTH))))
        else $error("entry count above depth");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind positional_insert_delete_list plid_checker #(
    .DEPTH (DEPTH)
) u_plid_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/list_checker.sv =====
`timescale 1ns / 1ps

module list_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [plid_pkg::S_TDATA_W-1:0]   s_tdata,    // position, payload
    input  logic [plid_pkg::FUNC_W-1:0]      s_tuser,    // func
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [plid_pkg::M_TDATA_W-1:0]   m_tdata,    // read_data, entry_count
    input  logic [plid_pkg::STATUS_W-1:0]    m_tuser,    // status
    output int                               fail_count,
    output int                               pending,
    output int                               checked
);
    import plid_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int IDX_W      = $clog2(LIST_DEPTH);

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PAYLOAD_W-1:0] read_data;
        logic [ECOUNT_W-1:0]  entry_count;
    } list_result_t;

    // Shadow copy of the list and its length
    logic [PAYLOAD_W-1:0] list_words [LIST_DEPTH];
    int                   list_len;

    // Results still owed by the block, oldest first
    list_result_t         owed_results [$];

    // Apply one operation to the shadow list and return the result it gives
    function automatic list_result_t apply_op(input logic [FUNC_W-1:0]    func,
                                              input logic [POS_W-1:0]     pos,
                                              input logic [PAYLOAD_W-1:0] word);
        list_result_t res;
        int           i;
        res.status    = ST_OK;
        res.read_data = '0;
        unique case (func)
            FN_INSERT:
            begin
                if (list_len >= LIST_DEPTH)
                    res.status = ST_FULL;
                else if (int'(pos) > list_len)
                    res.status = ST_NOPOS;
                else
                begin
                    // open a hole at pos by shifting the tail up
                    for (i = list_len; i > int'(pos); i--)
                        list_words[IDX_W'(i)] = list_words[IDX_W'(i-1)];
                    list_words[IDX_W'(pos)] = word;
                    list_len++;
                end
            end
            FN_DELETE:
            begin
                if (int'(pos) >= list_len)
                    res.status = ST_NOPOS;
                else
                begin
                    // close the gap by shifting the tail down
                    for (i = int'(pos); i + 1 < list_len; i++)
                        list_words[IDX_W'(i)] = list_words[IDX_W'(i+1)];
                    list_len--;
                end
            end
            FN_READ:
            begin
                if (int'(pos) >= list_len)
                    res.status = ST_NOPOS;
                else
                    res.read_data = list_words[IDX_W'(pos)];
            end
            FN_OVERWRITE:
            begin
                if (int'(pos) >= list_len)
                    res.status = ST_NOPOS;
                else
                    list_words[IDX_W'(pos)] = word;
            end
            FN_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        res.entry_count = ECOUNT_W'(list_len);
        return res;
    endfunction

    // Watch both channels; compare results first, then predict new work
    always @(posedge clk or negedge rst_n)
    begin : watch
        list_result_t got;
        list_result_t want;
        int           k;
        if (!rst_n)
        begin
            for (k = 0; k < LIST_DEPTH; k++)
                list_words[IDX_W'(k)] = '0;
            list_len = 0;
            owed_results.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status      = m_tuser;
                got.read_data   = m_tdata[PAYLOAD_W-1:0];
                got.entry_count = m_tdata[PAYLOAD_W +: ECOUNT_W];
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result: status %0d data %h count %0d",
                             $time, got.status, got.read_data, got.entry_count);
                    fail_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    checked++;
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                    if (got.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, got.read_data);
                        fail_count++;
                    end
                    if (got.entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, got.entry_count);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                owed_results.push_back(apply_op(s_tuser, s_tdata[POS_W-1:0],
                                                s_tdata[POS_W +: PAYLOAD_W]));
            pending = owed_results.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import plid_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_OFF     = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_ACCESS,
        MIX_NOISE
    } mix_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [FUNC_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    int fail_count;
    int pending;
    int checked;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int sent         = 0;
    int est_len      = 0;
    int quiet_cycles = 0;
    int sink_seen    = 0;

    always #4 clk = ~clk;

    positional_insert_delete_list dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    list_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    function automatic logic [PAYLOAD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Pick a position around the current list length, sometimes far off
    function automatic logic [POS_W-1:0] pick_pos(input bit for_insert);
        int hi;
        int r;
        hi = for_insert ? est_len : est_len - 1;
        r  = $urandom_range(0, 99);
        if (hi < 0 || r < 12)
            return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        if (r < 22)
            return POS_W'(hi);
        if (r < 30)
            return '0;
        return POS_W'($urandom_range(0, hi));
    endfunction

    // Offer one transaction, idling first at random, and hold until accepted
    task automatic send_item(input logic [FUNC_W-1:0]    func,
                             input logic [POS_W-1:0]     pos,
                             input logic [PAYLOAD_W-1:0] word);
        if (src_idle_en)
            while ($urandom_range(0, 99) < 20)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {1'b0, word, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
        // track the list length to steer later positions
        unique case (func)
            FN_INSERT:
                if (est_len < LIST_DEPTH && int'(pos) <= est_len)
                    est_len++;
            FN_DELETE:
                if (int'(pos) < est_len)
                    est_len--;
            FN_CLEAR:
                est_len = 0;
            default:
                ;
        endcase
    endtask

    // Receiver: random back-pressure, plus two long hold-offs
    initial
    begin : sink
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sink_seen++;
            if (m_tvalid && m_tready && (sink_seen == 200 || sink_seen == 700))
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            else
                m_tready <= !sink_idle_en || ($urandom_range(0, 99) >= 20);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: watchdog: no transaction for %0d cycles", $time, quiet_cycles);
                $display("positional_insert_delete_list: mismatch");
                $finish;
            end
        end
    end

    initial
    begin : stim
        int                n;
        int                k;
        int                burst;
        int                r;
        mix_t              mode;
        logic [FUNC_W-1:0] func;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, ends of the list, unused codes, clear
        send_item(FN_READ, 7'd0, '0);
        send_item(FN_DELETE, 7'd0, '0);
        send_item(FN_OVERWRITE, 7'd0, '1);
        send_item(FN_INSERT, 7'd1, '1);
        send_item(FN_INSERT, 7'd127, '1);
        send_item(FN_INSERT, 7'd0, '1);
        send_item(FN_INSERT, 7'd0, '0);
        send_item(FN_INSERT, 7'd2, 64'h5555_5555_5555_5555);
        send_item(FN_READ, 7'd0, '0);
        send_item(FN_READ, 7'd1, '1);
        send_item(FN_READ, 7'd2, '0);
        send_item(FN_READ, 7'd3, '0);
        send_item(FN_OVERWRITE, 7'd1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(FN_READ, 7'd1, '0);
        send_item(FN_OVERWRITE, 7'd127, '1);
        send_item(FN_DELETE, 7'd0, '0);
        send_item(FN_DELETE, 7'd1, '0);
        send_item(FN_READ, 7'd0, '0);
        send_item(3'd5, 7'd127, '1);
        send_item(3'd6, 7'd64, rand_word());
        send_item(3'd7, 7'd0, '1);
        send_item(FN_CLEAR, 7'd127, '1);
        send_item(FN_READ, 7'd0, '0);
        send_item(FN_DELETE, 7'd127, '0);

        // Fill the list, then poke it while full
        while (est_len < LIST_DEPTH)
            send_item(FN_INSERT, POS_W'($urandom_range(0, est_len)), rand_word());
        send_item(FN_INSERT, 7'd127, rand_word());
        send_item(FN_INSERT, 7'd0, rand_word());
        send_item(FN_INSERT, POS_W'(LIST_DEPTH), rand_word());
        send_item(FN_READ, POS_W'(LIST_DEPTH - 1), '0);
        send_item(FN_READ, POS_W'(LIST_DEPTH), '0);
        send_item(FN_OVERWRITE, POS_W'(LIST_DEPTH - 1), rand_word());
        send_item(FN_DELETE, POS_W'(LIST_DEPTH - 1), '0);
        send_item(FN_INSERT, POS_W'(LIST_DEPTH - 1), rand_word());
        send_item(FN_READ, POS_W'(LIST_DEPTH - 1), '0);

        // Random bursts, each leaning toward growth, shrinkage, access or noise
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            mode  = mix_t'($urandom_range(0, 3));
            burst = $urandom_range(20, 60);
            for (k = 0; k < burst && n < RANDOM_ITEMS; k++)
            begin
                // keep a stretch free of idling on both sides
                src_idle_en  = !(n >= 400 && n < 600);
                sink_idle_en = src_idle_en;
                r = $urandom_range(0, 99);
                unique case (mode)
                    MIX_GROW:
                        func = (r < 60) ? FN_INSERT : (r < 72) ? FN_DELETE :
                               (r < 86) ? FN_READ : FN_OVERWRITE;
                    MIX_SHRINK:
                        func = (r < 15) ? FN_INSERT : (r < 70) ? FN_DELETE :
                               (r < 85) ? FN_READ : FN_OVERWRITE;
                    MIX_ACCESS:
                        func = (r < 25) ? FN_INSERT : (r < 40) ? FN_DELETE :
                               (r < 70) ? FN_READ : FN_OVERWRITE;
                    default:
                        func = FUNC_W'($urandom_range(0, (1 << FUNC_W) - 1));
                endcase
                if (mode != MIX_NOISE && $urandom_range(0, 199) == 0)
                    func = FN_CLEAR;
                send_item(func, pick_pos(func == FN_INSERT), rand_word());
                n++;
            end
        end
        s_tvalid <= 1'b0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;

        // Drain outstanding results, then let the pipeline settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d items: corner cases, a fill to %0d entries, random mixed bursts",
                 sent, LIST_DEPTH);
        $display("checked %0d results across two long receiver stalls; %0d failures",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("positional_insert_delete_list: match");
        else
            $display("positional_insert_delete_list: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/plid_pkg.sv
src/plid_cell.sv
src/plid_or_tree.sv
src/positional_insert_delete_list.sv
src/plid_checker.sv
dv/list_checker.sv
dv/tb.sv
